[rtl/sbs_pkg.sv]
// ----------------------------------------------------------------------------
// sbs_pkg
// shared types and constants of the sorted table binary search block
// ----------------------------------------------------------------------------
package sbs_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int DATA_W      = 32;
  localparam int IDX_W       = 10;                       // entry_index field
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);      // table address
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);  // entry count / bounds

  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_SEARCH = 1'b1;

  typedef struct packed {
    logic                     func;
    logic [IDX_W-1:0]         entry_index;
    logic signed [DATA_W-1:0] entry_value;
    logic signed [DATA_W-1:0] search_key;
  } in_item_t;

  typedef struct packed {
    logic             found;
    logic [CNT_W-1:0] position;
  } out_item_t;

  // table port request from the search engine
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wdata;
  } ram_req_t;

endpackage

[rtl/sbs_ram.sv]
// ----------------------------------------------------------------------------
// sbs_ram
// generic single-port synchronous ram with registered read
// ----------------------------------------------------------------------------
module sbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/sbs_engine.sv]
// ----------------------------------------------------------------------------
// sbs_engine
// command decode and binary search sequencer, one table probe per cycle
// ----------------------------------------------------------------------------
module sbs_engine (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  sbs_pkg::in_item_t        in_item,
  input  logic [sbs_pkg::CNT_W-1:0] count,
  output sbs_pkg::ram_req_t        ram_req,
  input  logic [sbs_pkg::DATA_W-1:0] ram_rdata,
  output logic                     out_valid,
  output sbs_pkg::out_item_t       out_item
);
  import sbs_pkg::*;

  typedef enum logic {S_IDLE, S_SEARCH} state_t;

  state_t                    state_r, state_nxt;
  logic [CNT_W-1:0]          low_r, low_nxt;   // lowest candidate
  logic [CNT_W-1:0]          hi_r, hi_nxt;     // one past highest candidate
  logic [ADDR_W-1:0]         mid_r, mid_nxt;   // entry being probed
  logic signed [DATA_W-1:0]  key_r, key_nxt;
  logic                      out_valid_r, out_valid_nxt;
  out_item_t                 out_item_r, out_item_nxt;

  logic                      accept;
  logic signed [DATA_W-1:0]  probe;
  logic [CNT_W:0]            sum_lo, sum_hi;
  logic [ADDR_W-1:0]         mid_go_lo, mid_go_hi, mid_first;
  logic [CNT_W-1:0]          mid_ext, mid_inc;
  logic [CNT_W-1:0]          count_m1;

  assign accept   = start && (state_r == S_IDLE);
  assign probe    = $signed(ram_rdata);
  assign mid_ext  = CNT_W'(mid_r);
  assign mid_inc  = mid_ext + CNT_W'(1);
  assign count_m1 = count - CNT_W'(1);
  assign mid_first = count_m1[ADDR_W:1];
  // both candidate next probes, picked by the compare
  assign sum_lo    = {1'b0, low_r} + {1'b0, mid_ext} - (CNT_W+1)'(1);
  assign sum_hi    = {1'b0, mid_ext} + {1'b0, hi_r};
  assign mid_go_lo = sum_lo[ADDR_W:1];
  assign mid_go_hi = sum_hi[ADDR_W:1];

  always_comb begin
    state_nxt     = state_r;
    low_nxt       = low_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    key_nxt       = key_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    ram_req.we    = 1'b0;
    ram_req.addr  = mid_r;
    ram_req.wdata = in_item.entry_value;

    unique case (state_r)
      S_IDLE: begin
        if (accept && in_item.func == FUNC_WRITE) begin
          ram_req.addr = in_item.entry_index[ADDR_W-1:0];
          ram_req.we   = (CNT_W'(in_item.entry_index) < CNT_W'(TABLE_DEPTH));
        end else if (accept) begin
          key_nxt = in_item.search_key;
          if (count == '0) begin
            out_valid_nxt         = 1'b1;
            out_item_nxt.found    = 1'b0;
            out_item_nxt.position = '0;
          end else begin
            low_nxt      = '0;
            hi_nxt       = count;
            mid_nxt      = mid_first;
            ram_req.addr = mid_first;
            state_nxt    = S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        if (probe == key_r) begin
          out_valid_nxt         = 1'b1;
          out_item_nxt.found    = 1'b1;
          out_item_nxt.position = mid_inc;
          state_nxt             = S_IDLE;
        end else if (key_r < probe) begin
          hi_nxt = mid_ext;
          if (low_r < mid_ext) begin
            mid_nxt      = mid_go_lo;
            ram_req.addr = mid_go_lo;
          end else begin
            out_valid_nxt         = 1'b1;
            out_item_nxt.found    = 1'b0;
            out_item_nxt.position = '0;
            state_nxt             = S_IDLE;
          end
        end else begin
          low_nxt = mid_inc;
          if (mid_inc < hi_r) begin
            mid_nxt      = mid_go_hi;
            ram_req.addr = mid_go_hi;
          end else begin
            out_valid_nxt         = 1'b1;
            out_item_nxt.found    = 1'b0;
            out_item_nxt.position = '0;
            state_nxt             = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    low_r      <= low_nxt;
    hi_r       <= hi_nxt;
    mid_r      <= mid_nxt;
    key_r      <= key_nxt;
    out_item_r <= out_item_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

[rtl/sorted_table_binary_search.sv]
// ----------------------------------------------------------------------------
// sorted_table_binary_search
// table of signed 32-bit entries with write and binary search commands
// write: busy stays low, no result
// search: busy while probing, 1 to log2(TABLE_DEPTH)+1 (11) probes; result strobe in
//   the cycle after the last probe, when the next transfer can also be taken
// search with entry_count zero: result strobe in the next cycle, busy stays low
// sync reset clears entry_count and control; table contents are not cleared
// the receiver cannot stall, every result is a one-cycle out_valid transfer
// ----------------------------------------------------------------------------
module sorted_table_binary_search (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  sbs_pkg::in_item_t          in_item,
  output logic                       out_valid,
  output sbs_pkg::out_item_t         out_item,
  input  logic                       cfg_we,
  input  logic [sbs_pkg::CNT_W-1:0]  cfg_wdata
);
  import sbs_pkg::*;

  logic [CNT_W-1:0]  entry_count_r;
  logic [CNT_W-1:0]  count_eff;
  ram_req_t          ram_req;
  logic [DATA_W-1:0] ram_rdata;

  // entry_count register; the user must write it only while idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= '0;
    end else if (cfg_we) begin
      entry_count_r <= cfg_wdata;
    end
  end

  // counts above the table size search the whole table
  assign count_eff = (entry_count_r > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                            : entry_count_r;

  // sequencer: decodes commands, walks low/high bounds, drives the table port
  sbs_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .count     (count_eff),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // sorted table, one access per cycle, read data in the next cycle
  sbs_ram #(
    .WIDTH (DATA_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_req.we),
    .addr  (ram_req.addr),
    .wdata (ram_req.wdata),
    .rdata (ram_rdata)
  );

endmodule

[rtl/sbs_checker.sv]
// ----------------------------------------------------------------------------
// sbs_checker
// port-level checks of the sorted table binary search block
// ----------------------------------------------------------------------------
module sbs_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  sbs_pkg::in_item_t   in_item,
  input  logic                out_valid,
  input  sbs_pkg::out_item_t  out_item
);
  import sbs_pkg::*;

  // a miss reports position zero
  a_miss_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.found |-> out_item.position == '0)
    else $error("miss with nonzero position");

  // a hit reports a one-based position inside the table
  a_hit_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.found |->
      out_item.position != '0 && out_item.position <= CNT_W'(TABLE_DEPTH))
    else $error("hit position out of range");

  // a write transfer never produces a result
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_item.func == FUNC_WRITE |=> !out_valid)
    else $error("result after write");

  // the end of a search always delivers its result
  a_search_done: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) && $past(rst_n) |-> out_valid)
    else $error("search ended without result");

endmodule

bind sorted_table_binary_search sbs_checker u_sbs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_item  (out_item)
);

[dv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// checks the sorted table binary search block: a directed table of writes and
// searches, then randomized phases that load sorted tables of varying sizes,
// set entry_count and run searches; every result is compared against a hand-given
// answer or a behavioral search over a shadow copy of the table
// ----------------------------------------------------------------------------
module tb_top;
  import sbs_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 12;
  localparam int SETTLE       = 14;                 // longest search plus margin
  localparam int RANDOM_ITEMS = 1600;
  localparam int COUNT_MAX    = (1 << CNT_W) - 1;   // largest entry_count value
  localparam int S32_MIN      = 32'sh8000_0000;
  localparam int S32_MAX      = 32'sh7fff_ffff;

  // one row of the directed table: optional entry_count write, then a transfer
  typedef struct {
    bit               set_count;
    logic [CNT_W-1:0] count_val;
    in_item_t         item;
    bit               typed;         // expected result given by hand
    out_item_t        typed_result;
  } directed_row_t;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  in_item_t   in_item;
  logic       out_valid;
  out_item_t  out_item;
  logic       cfg_we;
  logic [CNT_W-1:0] cfg_wdata;

  // shadow of the block: table contents and entry_count
  logic signed [DATA_W-1:0] shadow_entries [TABLE_DEPTH];
  logic [CNT_W-1:0]         shadow_count;

  out_item_t     pending_results [$];  // search answers still to come, oldest first
  out_item_t     got_result;
  directed_row_t directed_rows [$];
  int            error_count;
  int            items_sent;
  bit            steady_run;           // no sender gaps while set

  sorted_table_binary_search DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // 100 MHz clock
  always begin
    clk = 1'b0;
    #CLK_HALF;
    clk = 1'b1;
    #CLK_HALF;
  end

  // safety net against a hung handshake
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  // binary search over the shadow table with the current entry_count,
  // stopping at the first equal probe; counts above the depth are clamped
  function automatic out_item_t predict_search(input logic signed [DATA_W-1:0] key);
    out_item_t answer;
    int        lo;
    int        hi;
    int        mid;
    int        span;
    answer = '0;
    span   = (shadow_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(shadow_count);
    lo     = 0;
    hi     = span - 1;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (key == shadow_entries[mid]) begin
        answer.found    = 1'b1;
        answer.position = CNT_W'(mid + 1);
        break;
      end else if (key < shadow_entries[mid]) begin
        hi = mid - 1;
      end else begin
        lo = mid + 1;
      end
    end
    return answer;
  endfunction

  // fully random item, also used as filler for fields the operation ignores
  function automatic in_item_t rand_item();
    in_item_t r;
    r.func        = 1'($urandom_range(0, 1));
    r.entry_index = IDX_W'($urandom_range(0, TABLE_DEPTH - 1));
    r.entry_value = $urandom;
    r.search_key  = $urandom;
    return r;
  endfunction

  function automatic directed_row_t dir_row(input bit set_count, input int count_val,
                                            input logic func, input int idx,
                                            input int val, input int key,
                                            input bit typed, input logic fnd,
                                            input int pos);
    directed_row_t row;
    row.set_count             = set_count;
    row.count_val             = CNT_W'(count_val);
    row.item.func             = func;
    row.item.entry_index      = IDX_W'(idx);
    row.item.entry_value      = val;
    row.item.search_key       = key;
    row.typed                 = typed;
    row.typed_result.found    = fnd;
    row.typed_result.position = CNT_W'(pos);
    return row;
  endfunction

  // one input transfer: optional random gap, then hold start until busy is
  // low at a clock edge; the shadow and the expected results move on at the
  // edge where the transfer happens
  task automatic send_item(input in_item_t item, input bit typed,
                           input out_item_t typed_result);
    int gap;
    gap = 0;
    if (!steady_run && $urandom_range(0, 99) < 28) gap = $urandom_range(1, 4);
    if (gap != 0) begin
      start   <= 1'b0;
      in_item <= rand_item();   // garbage while idle must be ignored
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= item;
    do @(posedge clk); while (busy);
    if (item.func == FUNC_SEARCH) begin
      pending_results.push_back(typed ? typed_result : predict_search(item.search_key));
    end else begin
      shadow_entries[item.entry_index] = item.entry_value;
    end
    items_sent++;
  endtask

  task automatic write_entry(input int idx, input int val);
    in_item_t it;
    it             = rand_item();
    it.func        = FUNC_WRITE;
    it.entry_index = IDX_W'(idx);
    it.entry_value = val;
    send_item(it, 1'b0, '0);
  endtask

  // entry_count changes only with the block idle: drain results, let any
  // search still in flight finish, then a single write strobe
  task automatic write_count(input int val);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= CNT_W'(val);
    @(posedge clk);
    cfg_we       <= 1'b0;
    shadow_count  = CNT_W'(val);
  endtask

  // one phase: load load_n sorted entries from index 0, set entry_count,
  // then searches mixed with a few stray writes that may unsort the table;
  // count_val exceeds this run only once every entry is written, so no empty entry gets probed
  task automatic run_phase(input int load_n, input int count_val, input int n_searches);
    int                       vals [$];
    int                       style;
    int                       pick;
    int                       span;
    logic signed [DATA_W-1:0] key;
    in_item_t                 it;
    style = $urandom_range(0, 2);
    for (int i = 0; i < load_n; i++) begin
      case (style)
        0:       vals.push_back($urandom);
        1:       vals.push_back(int'($urandom_range(0, load_n / 2 + 2)) - 8); // duplicates
        default: vals.push_back($urandom_range(0, 1) ? S32_MIN + int'($urandom_range(0, 3))
                                                     : S32_MAX - int'($urandom_range(0, 3)));
      endcase
    end
    vals.sort();
    if ($urandom_range(0, 1)) begin
      for (int i = 0; i < load_n; i++) write_entry(i, vals[i]);
    end else begin
      for (int i = load_n - 1; i >= 0; i--) write_entry(i, vals[i]);
    end
    write_count(count_val);
    span = (shadow_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(shadow_count);
    for (int s = 0; s < n_searches; s++) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        // stray write, half of them inside the searched range
        if (pick < 3 && span != 0) write_entry($urandom_range(0, span - 1), $urandom);
        else write_entry($urandom_range(0, TABLE_DEPTH - 1), $urandom);
        continue;
      end
      pick = $urandom_range(0, 99);
      if (span != 0 && pick < 50) begin
        key = shadow_entries[$urandom_range(0, span - 1)];            // present
      end else if (span != 0 && pick < 65) begin
        key = shadow_entries[$urandom_range(0, span - 1)];            // neighbor
        key = $urandom_range(0, 1) ? key + 1 : key - 1;
      end else if (pick < 75) begin
        case ($urandom_range(0, 3))
          0:       key = S32_MIN;
          1:       key = S32_MAX;
          2:       key = 0;
          default: key = -1;
        endcase
      end else begin
        key = $urandom;
      end
      it            = rand_item();
      it.func       = FUNC_SEARCH;
      it.search_key = key;
      send_item(it, 1'b0, '0);
    end
  endtask

  // result checker: a strobe is a transfer, compared with the oldest answer
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("result with none pending: found %0d position %0d",
               out_item.found, out_item.position);
        error_count++;
      end else begin
        got_result = pending_results.pop_front();
        if (out_item.found !== got_result.found) begin
          $error("found: expected %0d, got %0d", got_result.found, out_item.found);
          error_count++;
        end
        if (out_item.position !== got_result.position) begin
          $error("position: expected %0d, got %0d", got_result.position, out_item.position);
          error_count++;
        end
      end
    end
  end

  // stimulus
  initial begin
    int phase_no;
    int items_goal;
    int load_n;
    int count_val;
    int pick;
    int drain;

    start        = 1'b0;
    in_item      = '0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    rst_n        = 1'b0;
    steady_run   = 1'b0;
    error_count  = 0;
    items_sent   = 0;
    shadow_count = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      shadow_entries[i] = '0;
    end

    // directed table: count of zero after reset, both extremes of the value
    // range, present and absent keys, top index written, an unsorted table,
    // a single entry table
    //                     cfg  count func         idx   value           key
    //                                                                   typed fnd pos
    directed_rows = '{
      dir_row(0, 0, FUNC_SEARCH, 0,    0,              0,           1, 0, 0),
      dir_row(0, 0, FUNC_SEARCH, 0,    0,              S32_MIN,     1, 0, 0),
      dir_row(0, 0, FUNC_WRITE,  0,    S32_MIN,        0,           0, 0, 0),
      dir_row(0, 0, FUNC_WRITE,  1,    -5,             0,           0, 0, 0),
      dir_row(0, 0, FUNC_WRITE,  2,    0,              0,           0, 0, 0),
      dir_row(0, 0, FUNC_WRITE,  3,    7,              0,           0, 0, 0),
      dir_row(0, 0, FUNC_WRITE,  4,    S32_MAX,        0,           0, 0, 0),
      dir_row(0, 0, FUNC_WRITE,  1023, 32'sh5555_5555, 0,           0, 0, 0),
      dir_row(0, 0, FUNC_WRITE,  512,  32'shaaaa_aaaa, 0,           0, 0, 0),
      dir_row(1, 5, FUNC_SEARCH, 0,    0,              S32_MIN,     1, 1, 1),
      dir_row(0, 0, FUNC_SEARCH, 0,    0,              S32_MAX,     1, 1, 5),
      dir_row(0, 0, FUNC_SEARCH, 0,    0,              0,           1, 1, 3),
      dir_row(0, 0, FUNC_SEARCH, 0,    0,              7,           1, 1, 4),
      dir_row(0, 0, FUNC_SEARCH, 0,    0,              -5,          1, 1, 2),
      dir_row(0, 0, FUNC_SEARCH, 0,    0,              3,           1, 0, 0),
      dir_row(0, 0, FUNC_SEARCH, 0,    0,              S32_MIN + 1, 1, 0, 0),
      dir_row(0, 0, FUNC_SEARCH, 0,    0,              S32_MAX - 1, 1, 0, 0),
      dir_row(0, 0, FUNC_WRITE,  2,    100,            0,           0, 0, 0),
      dir_row(0, 0, FUNC_SEARCH, 0,    0,              7,           0, 0, 0),
      dir_row(0, 0, FUNC_SEARCH, 0,    0,              100,         0, 0, 0),
      dir_row(1, 1, FUNC_SEARCH, 0,    0,              S32_MIN,     1, 1, 1),
      dir_row(0, 0, FUNC_SEARCH, 0,    0,              -5,          1, 0, 0),
      dir_row(1, 0, FUNC_SEARCH, 0,    0,              S32_MAX,     1, 0, 0)
    };

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].set_count) write_count(directed_rows[i].count_val);
      send_item(directed_rows[i].item, directed_rows[i].typed,
                directed_rows[i].typed_result);
    end

    // random phases; the full table load counts toward the total
    items_goal = items_sent + RANDOM_ITEMS;
    phase_no   = 0;
    while (items_sent < items_goal) begin
      steady_run = (phase_no == 3);   // one phase with back to back transfers
      if (phase_no == 0) begin
        load_n = $urandom_range(8, 24);
        run_phase(load_n, load_n, $urandom_range(20, 40));
      end else if (phase_no == 1) begin
        // every entry written from here on; count beyond depth gets clamped
        run_phase(TABLE_DEPTH, COUNT_MAX, 80);
      end else if (phase_no == 2) begin
        run_phase(0, TABLE_DEPTH, 40);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          // reuse the whole table, by now unsorted in places
          case ($urandom_range(0, 2))
            0:       count_val = TABLE_DEPTH;
            1:       count_val = COUNT_MAX;
            default: count_val = $urandom_range(0, COUNT_MAX);
          endcase
          run_phase(0, count_val, $urandom_range(20, 50));
        end else if (pick < 14) begin
          run_phase(0, 0, $urandom_range(10, 20));
        end else begin
          load_n    = (pick < 20) ? $urandom_range(41, 150) : $urandom_range(1, 40);
          count_val = ($urandom_range(0, 9) == 0) ? $urandom_range(0, load_n) : load_n;
          run_phase(load_n, count_val, $urandom_range(10, 60));
        end
      end
      phase_no++;
    end
    steady_run = 1'b0;

    // wind down: wait for the last answers, then let the block settle
    start <= 1'b0;
    drain  = 0;
    while (pending_results.size() != 0 && drain < 2000) begin
      @(posedge clk);
      drain++;
    end
    repeat (SETTLE) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d search results never arrived", pending_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/sbs_pkg.sv
rtl/sbs_ram.sv
rtl/sbs_engine.sv
rtl/sorted_table_binary_search.sv
rtl/sbs_checker.sv
dv/tb_top.sv
